// File: rtl/core/bbcc_pkg.sv
// ----------------------------------------------------------------------------
// bbcc_pkg
// Shared types, codes and helpers of the basic block code cache.
// ----------------------------------------------------------------------------
package bbcc_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF     = 16;
    localparam int BLOCK_WORDS_DEF = 64;

    // Opcodes that end a basic block (top nibble of the word)
    localparam logic [3:0] OP_BR  = 4'h0;
    localparam logic [3:0] OP_JSR = 4'h4;
    localparam logic [3:0] OP_JMP = 4'hC;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD,
        ST_LOOK,
        ST_FETCH,
        ST_RESULT
    } state_t;

    // True for a branch, call or jump word
    function automatic logic ends_block(input logic [15:0] word);
        logic [3:0] op;
        op = word[15:12];
        return (op == OP_BR) || (op == OP_JSR) || (op == OP_JMP);
    endfunction

endpackage

// File: rtl/core/basic_block_code_cache_core.sv
// Steps: a clear, an ignored kind or a lookup on an empty table goes straight to
//   the result state; a word item passes the word state first; a lookup scans the
//   slots and, on a hit, fetches the word before its result.
// Flow: one item at a time; the next one is taken only once the result has moved
//   into the output register, which waits while out_stall holds a beat.
// Reset: rst_n clears the sequencer, fill count and open block at once; slot
//   and word memories hold undefined data until written, no clearing pass.
// ----------------------------------------------------------------------------
// basic_block_code_cache_core
// Code cache of basic blocks: builds blocks from streamed words, commits them
// to slots and scans the slots with one shared range compare unit on lookup.
// ----------------------------------------------------------------------------
module basic_block_code_cache_core #(
    parameter int ENTRIES     = bbcc_pkg::ENTRIES_DEF,
    parameter int BLOCK_WORDS = bbcc_pkg::BLOCK_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [15:0] instruction_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [3:0]  block_index,
    output logic [5:0]  offset,
    output logic [15:0] cached_word,
    output logic        block_closed,
    output logic        truncated
);

    localparam int SW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int LW    = $clog2(BLOCK_WORDS + 1);
    localparam int DEPTH = ENTRIES * BLOCK_WORDS;
    localparam int WAW   = $clog2(DEPTH);

    bbcc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] used_reg, used_next;
    logic          open_reg, open_next;
    logic [15:0]   open_start_reg, open_start_next;
    logic [LW-1:0] open_len_reg, open_len_next;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   word_reg, word_next;
    logic [SW-1:0] scan_reg, scan_next;

    logic          res_hit_reg, res_hit_next;
    logic [3:0]    res_idx_reg, res_idx_next;
    logic [5:0]    res_off_reg, res_off_next;
    logic [15:0]   res_cw_reg, res_cw_next;
    logic          res_closed_reg, res_closed_next;
    logic          res_trunc_reg, res_trunc_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_hit_reg, out_hit_next;
    logic [3:0]    out_idx_reg, out_idx_next;
    logic [5:0]    out_off_reg, out_off_next;
    logic [15:0]   out_cw_reg, out_cw_next;
    logic          out_closed_reg, out_closed_next;
    logic          out_trunc_reg, out_trunc_next;

    // Block builder signals
    logic [SW-1:0] tgt_slot;
    logic [15:0]   cur_start;
    logic [LW-1:0] cur_len;
    logic [LW-1:0] new_len;
    logic          is_exit;
    logic          is_full;
    logic          closes;

    // Shared address unit
    logic [SW-1:0]  mul_slot;
    logic [WAW-1:0] slot_base;

    // Range compare unit
    logic [15:0]   rd_start;
    logic [LW-1:0] rd_len;
    logic [15:0]   lk_diff;
    logic          lk_in;
    logic          skip_last;
    logic          lk_hit;
    logic          scan_last;

    logic          word_wr_en;
    logic [WAW-1:0] word_wr_addr;
    logic [WAW-1:0] word_rd_addr;
    logic [15:0]   word_rd_data;
    logic          slot_wr_en;
    logic          out_free;

    // Target slot: next free one, or the last once the table is full
    assign tgt_slot  = (used_reg < CW'(ENTRIES)) ? SW'(used_reg) : SW'(ENTRIES - 1);
    assign cur_start = open_reg ? open_start_reg : addr_reg;
    assign cur_len   = open_reg ? open_len_reg : '0;
    assign new_len   = cur_len + LW'(1);
    assign is_exit   = bbcc_pkg::ends_block(word_reg);
    assign is_full   = (new_len == LW'(BLOCK_WORDS));
    assign closes    = is_exit || is_full;

    // Slot base address, shared by word writes and lookup reads
    assign mul_slot  = (state_reg == bbcc_pkg::ST_WORD) ? tgt_slot : scan_reg;
    assign slot_base = WAW'(WAW'(mul_slot) * WAW'(BLOCK_WORDS));

    // Range check of the slot under scan
    assign lk_diff   = addr_reg - rd_start;
    assign lk_in     = (addr_reg >= rd_start) && (17'(lk_diff) < 17'(rd_len));
    assign skip_last = open_reg && (used_reg == CW'(ENTRIES));
    assign lk_hit    = lk_in && !(skip_last && (scan_reg == SW'(ENTRIES - 1)));
    assign scan_last = ((CW'(scan_reg) + CW'(1)) == used_reg);

    assign word_wr_en   = (state_reg == bbcc_pkg::ST_WORD);
    assign word_wr_addr = slot_base + WAW'(cur_len);
    assign word_rd_addr = slot_base + WAW'(lk_diff);
    assign slot_wr_en   = (state_reg == bbcc_pkg::ST_WORD) && closes;
    assign out_free     = !out_valid_reg || !out_stall;

    bbcc_slot_table #(
        .SLOTS (ENTRIES),
        .LEN_W (LW)
    ) u_slot_table (
        .clk      (clk),
        .wr_en    (slot_wr_en),
        .wr_idx   (tgt_slot),
        .wr_start (cur_start),
        .wr_len   (new_len),
        .rd_idx   (scan_next),
        .rd_start (rd_start),
        .rd_len   (rd_len)
    );

    bbcc_word_store #(
        .DEPTH (DEPTH)
    ) u_word_store (
        .clk     (clk),
        .wr_en   (word_wr_en),
        .wr_addr (word_wr_addr),
        .wr_data (word_reg),
        .rd_addr (word_rd_addr),
        .rd_data (word_rd_data)
    );

    // Sequencer state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bbcc_pkg::ST_IDLE;
            used_reg       <= '0;
            open_reg       <= 1'b0;
            open_start_reg <= '0;
            open_len_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            open_reg       <= open_next;
            open_start_reg <= open_start_next;
            open_len_reg   <= open_len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        word_reg       <= word_next;
        scan_reg       <= scan_next;
        res_hit_reg    <= res_hit_next;
        res_idx_reg    <= res_idx_next;
        res_off_reg    <= res_off_next;
        res_cw_reg     <= res_cw_next;
        res_closed_reg <= res_closed_next;
        res_trunc_reg  <= res_trunc_next;
        out_hit_reg    <= out_hit_next;
        out_idx_reg    <= out_idx_next;
        out_off_reg    <= out_off_next;
        out_cw_reg     <= out_cw_next;
        out_closed_reg <= out_closed_next;
        out_trunc_reg  <= out_trunc_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        open_next       = open_reg;
        open_start_next = open_start_reg;
        open_len_next   = open_len_reg;
        addr_next       = addr_reg;
        word_next       = word_reg;
        scan_next       = scan_reg;
        res_hit_next    = res_hit_reg;
        res_idx_next    = res_idx_reg;
        res_off_next    = res_off_reg;
        res_cw_next     = res_cw_reg;
        res_closed_next = res_closed_reg;
        res_trunc_next  = res_trunc_reg;
        out_hit_next    = out_hit_reg;
        out_idx_next    = out_idx_reg;
        out_off_next    = out_off_reg;
        out_cw_next     = out_cw_reg;
        out_closed_next = out_closed_reg;
        out_trunc_next  = out_trunc_reg;

        // Drop the output beat once taken
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            bbcc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next       = address;
                    word_next       = instruction_word;
                    scan_next       = '0;
                    res_hit_next    = 1'b0;
                    res_idx_next    = '0;
                    res_off_next    = '0;
                    res_cw_next     = '0;
                    res_closed_next = 1'b0;
                    res_trunc_next  = 1'b0;
                    case (bbcc_pkg::kind_t'(kind))
                        bbcc_pkg::KIND_WORD:
                        begin
                            state_next = bbcc_pkg::ST_WORD;
                        end
                        bbcc_pkg::KIND_LOOKUP:
                        begin
                            state_next = (used_reg == '0) ? bbcc_pkg::ST_RESULT
                                                          : bbcc_pkg::ST_LOOK;
                        end
                        bbcc_pkg::KIND_CLEAR:
                        begin
                            used_next       = '0;
                            open_next       = 1'b0;
                            open_start_next = '0;
                            open_len_next   = '0;
                            state_next      = bbcc_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            state_next = bbcc_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            // Append the word, commit the block on a branch, call or jump or at the limit
            bbcc_pkg::ST_WORD:
            begin
                if (closes)
                begin
                    if (used_reg < CW'(ENTRIES))
                    begin
                        used_next = used_reg + CW'(1);
                    end
                    open_next       = 1'b0;
                    open_start_next = '0;
                    open_len_next   = '0;
                    res_closed_next = 1'b1;
                    res_trunc_next  = !is_exit;
                    res_idx_next    = 4'(tgt_slot);
                end
                else
                begin
                    open_next       = 1'b1;
                    open_start_next = cur_start;
                    open_len_next   = new_len;
                end
                state_next = bbcc_pkg::ST_RESULT;
            end

            // Check one slot per cycle, lowest first
            bbcc_pkg::ST_LOOK:
            begin
                if (lk_hit)
                begin
                    res_hit_next = 1'b1;
                    res_idx_next = 4'(scan_reg);
                    res_off_next = 6'(lk_diff);
                    state_next   = bbcc_pkg::ST_FETCH;
                end
                else if (scan_last)
                begin
                    state_next = bbcc_pkg::ST_RESULT;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end

            bbcc_pkg::ST_FETCH:
            begin
                res_cw_next = word_rd_data;
                state_next  = bbcc_pkg::ST_RESULT;
            end

            // Hand the result to the output register when it is free
            bbcc_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_idx_next    = res_idx_reg;
                    out_off_next    = res_off_reg;
                    out_cw_next     = res_cw_reg;
                    out_closed_next = res_closed_reg;
                    out_trunc_next  = res_trunc_reg;
                    state_next      = bbcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bbcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != bbcc_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign block_index  = out_idx_reg;
    assign offset       = out_off_reg;
    assign cached_word  = out_cw_reg;
    assign block_closed = out_closed_reg;
    assign truncated    = out_trunc_reg;

endmodule

// File: rtl/core/bbcc_slot_table.sv
// ----------------------------------------------------------------------------
// bbcc_slot_table
// Start address and length of every slot, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module bbcc_slot_table #(
    parameter int SLOTS = bbcc_pkg::ENTRIES_DEF,
    parameter int LEN_W = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_idx,
    input  logic [15:0]              wr_start,
    input  logic [LEN_W-1:0]         wr_len,
    input  logic [$clog2(SLOTS)-1:0] rd_idx,
    output logic [15:0]              rd_start,
    output logic [LEN_W-1:0]         rd_len
);

    logic [15:0]      start_mem [SLOTS];
    logic [LEN_W-1:0] len_mem   [SLOTS];

    // Commit a closed block
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_idx] <= wr_start;
            len_mem[wr_idx]   <= wr_len;
        end
    end

    // Read the slot under scan
    always_ff @(posedge clk)
    begin
        rd_start <= start_mem[rd_idx];
        rd_len   <= len_mem[rd_idx];
    end

endmodule

// File: rtl/core/bbcc_word_store.sv
// ----------------------------------------------------------------------------
// bbcc_word_store
// Instruction words of all slots, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbcc_word_store #(
    parameter int DEPTH = bbcc_pkg::ENTRIES_DEF * bbcc_pkg::BLOCK_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [15:0]              rd_data
);

    logic [15:0] mem [DEPTH];

    // Store an incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the word at the hit offset
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/bbcc_checker.sv
// ----------------------------------------------------------------------------
// bbcc_checker
// Port-level checks of the basic block code cache, bound to the top level.
// ----------------------------------------------------------------------------
module bbcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  kind,
    input logic [15:0] address,
    input logic [15:0] instruction_word,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [3:0]  block_index,
    input logic [5:0]  offset,
    input logic [15:0] cached_word,
    input logic        block_closed,
    input logic        truncated
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(block_index)
            && $stable(offset) && $stable(cached_word) && $stable(block_closed)
            && $stable(truncated))
        else $error("output beat changed while stalled");

    // An accepted item keeps the block busy on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // A lookup hit never reports a committed block
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !block_closed && !truncated)
        else $error("hit and block close in one result");

    // Truncation only comes with a closed block
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> block_closed)
        else $error("truncated without block close");

    // A miss or plain word result is all zeros
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit && !block_closed |->
            block_index == 4'd0 && offset == 6'd0 && cached_word == 16'd0)
        else $error("empty result carries data");

endmodule

bind basic_block_code_cache_core bbcc_checker u_bbcc_checker (.*);
